[hw/rtl/ccme_pkg.sv]
// ----------------------------------------------------------------------------
// ccme_pkg
// Shared types, register indexes and character tables for the control
// character mnemonic escaper.
// ----------------------------------------------------------------------------
package ccme_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned RUN_MAX  = 6;
    localparam int unsigned RUN_W    = 3;
    localparam int unsigned SEQ_W    = CHAR_W * RUN_MAX;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 1'd1;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = 16'hFFFF;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [SEQ_W-1:0]  seq_t;
    typedef logic [RUN_W-1:0]  run_len_t;
    typedef logic [CNT_W-1:0]  count_t;

    // Three-letter mnemonic, first letter in the top byte; two-letter
    // names leave the low byte zero.
    function automatic logic [23:0] mnemonic(input logic [4:0] code);
        logic [23:0] m;
        case (code)
            5'd0:    m = "NUL";
            5'd1:    m = "SOH";
            5'd2:    m = "STX";
            5'd3:    m = "ETX";
            5'd4:    m = "EOT";
            5'd5:    m = "ENQ";
            5'd6:    m = "ACK";
            5'd7:    m = "BEL";
            5'd8:    m = {"BS", 8'h00};
            5'd9:    m = {"HT", 8'h00};
            5'd10:   m = {"LF", 8'h00};
            5'd11:   m = {"VT", 8'h00};
            5'd12:   m = {"FF", 8'h00};
            5'd13:   m = {"CR", 8'h00};
            5'd14:   m = {"SO", 8'h00};
            5'd15:   m = {"SI", 8'h00};
            5'd16:   m = "DLE";
            5'd17:   m = "DC1";
            5'd18:   m = "DC2";
            5'd19:   m = "DC3";
            5'd20:   m = "DC4";
            5'd21:   m = "NAK";
            5'd22:   m = "SYN";
            5'd23:   m = "ETB";
            5'd24:   m = "CAN";
            5'd25:   m = {"EM", 8'h00};
            5'd26:   m = "SUB";
            5'd27:   m = "ESC";
            5'd28:   m = {"FS", 8'h00};
            5'd29:   m = {"GS", 8'h00};
            5'd30:   m = {"RS", 8'h00};
            default: m = {"US", 8'h00};
        endcase
        return m;
    endfunction

    function automatic char_t hex_digit(input logic [3:0] nib);
        char_t c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

[hw/rtl/ccme_expand.sv]
// ----------------------------------------------------------------------------
// ccme_expand
// Builds the character run for one byte: the byte itself, its <mnemonic>,
// or <0xHH>. First character sits in the top byte of seq.
// ----------------------------------------------------------------------------
module ccme_expand (
    input  ccme_pkg::char_t    code,
    output ccme_pkg::seq_t     seq,
    output ccme_pkg::run_len_t run_len
);

    logic [23:0] mnem;

    assign mnem = ccme_pkg::mnemonic(code[4:0]);

    always_comb begin
        if (code >= 8'h20 && code <= 8'h7E) begin
            seq     = {code, 40'h0};
            run_len = 3'd1;
        end else if (code < 8'h20) begin
            if (mnem[7:0] == 8'h00) begin
                seq     = {"<", mnem[23:8], ">", 16'h0};
                run_len = 3'd4;
            end else begin
                seq     = {"<", mnem, ">", 8'h0};
                run_len = 3'd5;
            end
        end else begin
            seq     = {"<0x", ccme_pkg::hex_digit(code[7:4]),
                       ccme_pkg::hex_digit(code[3:0]), ">"};
            run_len = 3'd6;
        end
    end

endmodule

[hw/rtl/control_char_mnemonic_escaper_top.sv]
// The first character of a run is on m_ in the cycle after the byte is taken.
// The output shift register sends a run one character per beat; a refused byte
// takes one beat. A new byte waits until the output is empty or the run ends.
// The next byte is taken in the same cycle the last character of a run leaves.
// Reset (synchronous, aresetn low) clears the count, the overflow flag, the
// output valid and the registers (limit off, capacity 65535).
// ----------------------------------------------------------------------------
// control_char_mnemonic_escaper_top
// Escapes bytes below 0x20 into mnemonic runs and 0x7F and up into <0xHH> runs,
// one character per output word, with an optional per-string output capacity limit.
// ----------------------------------------------------------------------------
module control_char_mnemonic_escaper_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_code,
    input  logic                              s_string_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_out_char,
    output logic                              m_last_of_run,
    output logic                              m_refused,
    input  logic                              cfg_wr_en,
    input  logic [ccme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_wdata
);

    logic              limit_en_reg;
    ccme_pkg::count_t  capacity_reg;
    ccme_pkg::count_t  count_reg, count_next;
    logic              ovf_reg, ovf_next;

    logic              valid_reg;
    ccme_pkg::seq_t    seq_reg;
    ccme_pkg::run_len_t rem_reg;
    logic              refused_reg;

    ccme_pkg::seq_t     exp_seq;
    ccme_pkg::run_len_t exp_len;
    ccme_pkg::count_t   cnt_base;
    logic               ovf_base;
    logic [16:0]        need;
    logic               refuse;
    logic               accept;
    logic               beat;
    logic               run_done;

    ccme_expand u_expand (
        .code    (s_code),
        .seq     (exp_seq),
        .run_len (exp_len)
    );

    assign cnt_base = s_string_start ? '0 : count_reg;
    assign ovf_base = s_string_start ? 1'b0 : ovf_reg;
    assign need     = {1'b0, cnt_base} + {14'h0, exp_len} + 17'd1;
    assign refuse   = limit_en_reg && (ovf_base || need > {1'b0, capacity_reg});

    assign beat     = valid_reg && m_ready;
    assign run_done = refused_reg || rem_reg == 3'd1;
    assign s_ready  = !valid_reg || (m_ready && run_done);
    assign accept   = s_valid && s_ready;

    assign m_valid       = valid_reg;
    assign m_out_char    = refused_reg ? 8'h00 : seq_reg[47:40];
    assign m_last_of_run = !refused_reg && rem_reg == 3'd1;
    assign m_refused     = refused_reg;

    always_comb begin
        count_next = cnt_base;
        ovf_next   = ovf_base;
        if (refuse) begin
            ovf_next = 1'b1;
        end else if (limit_en_reg) begin
            count_next = need[15:0] - 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_en_reg <= 1'b0;
            capacity_reg <= ccme_pkg::CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ccme_pkg::CFG_LIMIT_ENABLE: limit_en_reg <= cfg_wdata[0];
                ccme_pkg::CFG_OUT_CAPACITY: capacity_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            valid_reg   <= 1'b0;
            refused_reg <= 1'b0;
            rem_reg     <= '0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                ovf_reg     <= ovf_next;
                valid_reg   <= 1'b1;
                refused_reg <= refuse;
                rem_reg     <= refuse ? 3'd1 : exp_len;
            end else if (beat) begin
                if (run_done) begin
                    valid_reg <= 1'b0;
                end
                rem_reg <= rem_reg - 3'd1;
            end
        end
    end

    // payload shift register, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            seq_reg <= exp_seq;
        end else if (beat) begin
            seq_reg <= {seq_reg[39:0], 8'h00};
        end
    end

endmodule

[hw/rtl/ccme_checker.sv]
// ----------------------------------------------------------------------------
// ccme_checker
// Port-level checks for the escaper, bound to the top level.
// ----------------------------------------------------------------------------
module ccme_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_char,
    input logic       m_last_of_run,
    input logic       m_refused
);

    // refused word carries no character and no end mark
    a_refused_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_refused |-> m_out_char == 8'h00 && !m_last_of_run)
        else $error("refused word carries data");

    // a taken byte always produces a word next cycle
    a_accept_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted byte produced no word");

    // no new byte while a run is still mid-flight
    a_no_take_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run && !m_refused |-> !s_ready)
        else $error("input taken in the middle of a run");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char)
            && $stable(m_last_of_run) && $stable(m_refused))
        else $error("stalled output word changed");

endmodule

bind control_char_mnemonic_escaper_top ccme_checker u_ccme_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_char    (m_out_char),
    .m_last_of_run (m_last_of_run),
    .m_refused     (m_refused)
);
